[rtl/abcm_pkg.sv]
// Shared constants for the audio bit crusher and mix unit.
// Register map, configuration port widths and mix scaling; no dependencies.
package abcm_pkg;

   // configuration port widths
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // register field widths
   localparam int HOLD_W = 7;
   localparam int GAIN_W = 16;

   // gains are unsigned Q1.15
   localparam int GAIN_FRAC = 15;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_HOLD_FACTOR = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_KEEP_MASK   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_INVERT_MASK = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_DRY_GAIN    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_WET_GAIN    = 3'd4;

endpackage

[rtl/abcm_crush.sv]
// Level quantiser for the bit crusher: magnitude to level, mask and invert,
// then back to sample scale with the original sign. Uses abcm_pkg.
module abcm_crush #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int LEVEL_BITS   = 8
) (
   input  logic signed [SAMPLE_WIDTH-1:0] held,
   input  logic        [LEVEL_BITS-1:0]   keep_mask,
   input  logic        [LEVEL_BITS-1:0]   invert_mask,
   output logic signed [SAMPLE_WIDTH:0]   crushed
);
   import abcm_pkg::*;

   localparam longint FullScale = longint'(1) << (SAMPLE_WIDTH - 1);
   localparam longint LevelMax  = (longint'(1) << LEVEL_BITS) - 1;
   localparam int     NumLevels = 1 << LEVEL_BITS;
   localparam int     ProdW     = SAMPLE_WIDTH + LEVEL_BITS;

   logic [SAMPLE_WIDTH-1:0] mag;
   logic [ProdW-1:0]        scaled;
   logic [LEVEL_BITS-1:0]   level;
   logic [LEVEL_BITS-1:0]   level_mod;
   logic [SAMPLE_WIDTH-1:0] back;
   logic                    bypass;
   logic [SAMPLE_WIDTH-1:0] recon_tab [NumLevels];

   // reconstruction table: round(level * full scale / level max)
   for (genvar g = 0; g < NumLevels; g++) begin : g_recon
      localparam longint Recon = (longint'(g) * FullScale + LevelMax / 2) / LevelMax;
      assign recon_tab[g] = SAMPLE_WIDTH'(Recon);
   end

   // magnitude; the most negative sample maps to full scale
   assign mag = held[SAMPLE_WIDTH-1] ? (~held + 1'b1) : held;

   // round(mag * level max / full scale), times level max done as shift and subtract
   assign scaled = ({mag, {LEVEL_BITS{1'b0}}} - {{LEVEL_BITS{1'b0}}, mag})
                   + ProdW'(FullScale / 2);
   assign level  = scaled[ProdW-2 -: LEVEL_BITS];

   assign level_mod = (level & keep_mask) ^ invert_mask;
   assign back      = recon_tab[level_mod];

   // untouched path when every bit is kept and none inverted
   assign bypass = (&keep_mask) && (invert_mask == '0);

   always_comb begin
      if (bypass) begin
         crushed = {held[SAMPLE_WIDTH-1], held};
      end else if (held == '0) begin
         crushed = '0;
      end else if (held[SAMPLE_WIDTH-1]) begin
         crushed = -$signed({1'b0, back});
      end else begin
         crushed = $signed({1'b0, back});
      end
   end

endmodule

[rtl/audio_bit_crusher_mix_unit.sv]
// Audio bit crusher with sample-and-hold rate reduction and dry/wet mix.
// Top level; uses abcm_pkg and abcm_crush.
//
// Usage:
//   Samples enter on req_valid/req_stall/req_sample_in; a transfer happens
//   when req_valid is high and req_stall low. One mixed sample leaves per
//   input sample on rsp_valid/rsp_stall/rsp_sample_out, in order.
//   The user writes registers over csr_valid/csr_ready/csr_index/csr_data
//   only while the block is idle; the block does not enforce this, and
//   csr_ready is always high. An input register holds the sample and its
//   held sample, then crush, gain multiplies, sum and saturation run in
//   one pass into the output register, which drives rsp_valid.
//   Throughput is one sample per cycle while rsp_stall is low; each register
//   holds its item and advances when the one after it is empty or moving.
//   When the receiver stalls, req_stall rises once both registers hold an
//   item; nothing is dropped.
//   Synchronous reset empties both registers, clears the hold counter and
//   held sample, and loads hold_factor 1, keep_mask all ones,
//   invert_mask 0, dry_gain 0 and wet_gain unity.
module audio_bit_crusher_mix_unit #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int LEVEL_BITS   = 8,
   parameter int MAX_HOLD     = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]     req_sample_in,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]     rsp_sample_out,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic        [abcm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic        [abcm_pkg::CSR_DATA_W-1:0]  csr_data
);
   import abcm_pkg::*;

   localparam int CountW  = $clog2(MAX_HOLD);
   localparam int FactW   = $clog2(MAX_HOLD + 1);
   localparam int CmpW    = (FactW > HOLD_W) ? FactW : HOLD_W;
   localparam int DryW    = SAMPLE_WIDTH + GAIN_W + 1;
   localparam int WetW    = SAMPLE_WIDTH + GAIN_W + 2;
   localparam int SumW    = WetW + 1;
   localparam int SatMax  = (1 << (SAMPLE_WIDTH - 1)) - 1;

   // configuration registers
   logic [HOLD_W-1:0]     hold_factor_ff;
   logic [LEVEL_BITS-1:0] keep_mask_ff;
   logic [LEVEL_BITS-1:0] invert_mask_ff;
   logic [GAIN_W-1:0]     dry_gain_ff;
   logic [GAIN_W-1:0]     wet_gain_ff;

   // hold state
   logic [CountW-1:0]              hold_count_ff, hold_count_in;
   logic signed [SAMPLE_WIDTH-1:0] held_ff, held_in;
   logic [CmpW-1:0]                factor;
   logic [CmpW-1:0]                count_inc;

   // input and output registers
   logic                           v1_ff, v2_ff;
   logic signed [SAMPLE_WIDTH-1:0] s1_x_ff, s1_held_ff;
   logic signed [SAMPLE_WIDTH-1:0] out_ff, out_in;
   logic signed [SAMPLE_WIDTH:0]   crushed;
   logic signed [DryW-1:0]         dry_prod;
   logic signed [WetW-1:0]         wet_prod;
   logic signed [SumW-1:0]         mix_sum, mix_shift;
   logic                           free1, free2, accept;

   assign csr_ready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_factor_ff <= HOLD_W'(1);
         keep_mask_ff   <= '1;
         invert_mask_ff <= '0;
         dry_gain_ff    <= '0;
         wet_gain_ff    <= GAIN_W'(1 << GAIN_FRAC);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_HOLD_FACTOR: hold_factor_ff <= csr_data[HOLD_W-1:0];
            REG_KEEP_MASK:   keep_mask_ff   <= csr_data[LEVEL_BITS-1:0];
            REG_INVERT_MASK: invert_mask_ff <= csr_data[LEVEL_BITS-1:0];
            REG_DRY_GAIN:    dry_gain_ff    <= csr_data[GAIN_W-1:0];
            REG_WET_GAIN:    wet_gain_ff    <= csr_data[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // flow control: a register loads when empty or when it moves on
   assign free2     = !v2_ff || !rsp_stall;
   assign free1     = !v1_ff || free2;
   assign req_stall = !free1;
   assign accept    = req_valid && free1;

   // hold factor limited to 1..MAX_HOLD
   always_comb begin
      factor = CmpW'(hold_factor_ff);
      if (factor == '0) begin
         factor = CmpW'(1);
      end else if (factor > CmpW'(MAX_HOLD)) begin
         factor = CmpW'(MAX_HOLD);
      end
   end

   // running sample-and-hold counter
   assign count_inc = CmpW'(hold_count_ff) + CmpW'(1);
   always_comb begin
      held_in       = (hold_count_ff == '0) ? req_sample_in : held_ff;
      hold_count_in = (count_inc >= factor) ? '0 : count_inc[CountW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_count_ff <= '0;
         held_ff       <= '0;
      end else if (accept) begin
         hold_count_ff <= hold_count_in;
         held_ff       <= held_in;
      end
   end

   // input register: input sample and held sample
   always_ff @(posedge clock) begin
      if (free1) begin
         s1_x_ff    <= req_sample_in;
         s1_held_ff <= held_in;
      end
   end

   // crushed held sample
   abcm_crush #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .LEVEL_BITS   (LEVEL_BITS)
   ) u_crush (
      .held        (s1_held_ff),
      .keep_mask   (keep_mask_ff),
      .invert_mask (invert_mask_ff),
      .crushed     (crushed)
   );

   // gain products
   assign dry_prod = DryW'(s1_x_ff * $signed({1'b0, dry_gain_ff}));
   assign wet_prod = WetW'(crushed * $signed({1'b0, wet_gain_ff}));

   // sum, floor shift and saturate
   assign mix_sum   = SumW'(dry_prod) + SumW'(wet_prod);
   assign mix_shift = mix_sum >>> GAIN_FRAC;
   always_comb begin
      if (mix_shift > SumW'(SatMax)) begin
         out_in = SAMPLE_WIDTH'(SatMax);
      end else if (mix_shift < -SumW'(SatMax) - SumW'(1)) begin
         out_in = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      end else begin
         out_in = mix_shift[SAMPLE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (free2) begin
         out_ff <= out_in;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (free1) v1_ff <= req_valid;
         if (free2) v2_ff <= v1_ff;
      end
   end

   assign rsp_valid      = v2_ff;
   assign rsp_sample_out = out_ff;

endmodule
